// File: rtl/pixel_raster_op_unit_assert.svh
// Assertion macros shared by the raster-operation unit.
`ifndef PIXEL_RASTER_OP_UNIT_ASSERT_SVH
`define PIXEL_RASTER_OP_UNIT_ASSERT_SVH

// Implication checked in the same cycle, or later when the consequent starts with a delay.
`define PXROP_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error("raster-op assertion failed");

// Implication checked in the cycle after the antecedent.
`define PXROP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("raster-op assertion failed");

`endif

// File: rtl/pxrop_pkg.sv
// Types and constants of the per-pixel raster-operation unit.
package pxrop_pkg;

    localparam logic [15:0] KeyColor = 16'hFF0F;
    localparam int FadeDiv = 100;
    localparam int GrayDiv = 3;
    localparam logic [7:0] FadeReset = 8'd100;

    typedef enum logic [2:0] {
        KIND_KEY_COPY  = 3'd0,
        KIND_ADD       = 3'd1,
        KIND_HALVE     = 3'd2,
        KIND_FADE      = 3'd3,
        KIND_FADE_KEY  = 3'd4,
        KIND_GRAY      = 3'd5
    } t_kind;

    typedef enum logic {
        CFG_PIXEL_FORMAT = 1'b0,
        CFG_FADE_PERCENT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] src_pixel;
        logic [15:0] dest_pixel;
        logic        last_in;
    } t_req;

    typedef struct packed {
        logic [15:0] result_pixel;
        logic        write_enable;
        logic        last_out;
    } t_rsp;

    typedef struct packed {
        logic       pixel_format;
        logic [7:0] fade_percent;
    } t_cfg;

endpackage

// File: rtl/pixel_raster_op_unit.sv
// Top level of the per-pixel raster-operation unit.
//
//   Channel   Direction  Handshake                     Payload
//   request   in         start high, busy low          i_req (t_req)
//   result    out        o_rsp_strobe, one cycle        o_rsp (t_rsp)
//   config    in         i_cfg_valid and o_cfg_ready   i_cfg_index, i_cfg_data
//
// One request can be taken every cycle in which start is high and busy is low.
// Each result passes through the input register and then the result register,
// with the operation logic between them.
// Busy is high only while reset is asserted and for the cycle it is released.
// The receiver cannot stall, so the pipeline never holds.

`include "pixel_raster_op_unit_assert.svh"

module pixel_raster_op_unit import pxrop_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_rsp_strobe,
    output t_rsp       o_rsp,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic r_ready;
    logic r_req_valid;
    logic r_rsp_valid;
    t_req r_req;
    t_rsp r_rsp;
    t_cfg r_cfg;
    t_cfg n_cfg;
    t_rsp alu_rsp;
    logic req_take;

    assign busy = !r_ready;
    assign o_cfg_ready = r_ready;
    assign req_take = start && !busy;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PIXEL_FORMAT: n_cfg.pixel_format = i_cfg_data[0];
                CFG_FADE_PERCENT: n_cfg.fade_percent = i_cfg_data;
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_cfg.pixel_format <= 1'b0;
            r_cfg.fade_percent <= FadeReset;
        end else begin
            r_ready <= 1'b1;
            r_req_valid <= req_take;
            r_rsp_valid <= r_req_valid;
            r_cfg <= n_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_req <= i_req;
        end
        r_rsp <= alu_rsp;
    end

    pxrop_alu u_alu (
        .i_req (r_req),
        .i_cfg (r_cfg),
        .o_rsp (alu_rsp)
    );

    assign o_rsp_strobe = r_rsp_valid;
    assign o_rsp = r_rsp;

    `PXROP_ASSERT_IMPL(a_req_gives_result, start && !busy, ##2 o_rsp_strobe)
    `PXROP_ASSERT_IMPL(a_no_result_without_req, !(start && !busy), ##2 !o_rsp_strobe)
    `PXROP_ASSERT_IMPL(a_keyed_keeps_dest, o_rsp_strobe && !o_rsp.write_enable,
        (o_rsp.result_pixel == $past(r_req.dest_pixel)))
    `PXROP_ASSERT_IMPL(a_last_follows, o_rsp_strobe, (o_rsp.last_out == $past(r_req.last_in)))

endmodule

// File: rtl/pxrop_alu.sv
// Combinational raster-operation datapath for one pixel request.
module pxrop_alu import pxrop_pkg::*; (
    input  t_req i_req,
    input  t_cfg i_cfg,
    output t_rsp o_rsp
);

    function automatic logic [3:0] f_sat_add4(input logic [3:0] a, input logic [3:0] b);
        logic [4:0] s;
        s = 5'(a) + 5'(b);
        return s[4] ? 4'hF : s[3:0];
    endfunction

    function automatic logic [4:0] f_sat_add5(input logic [4:0] a, input logic [4:0] b);
        logic [5:0] s;
        s = 6'(a) + 6'(b);
        return s[5] ? 5'h1F : s[4:0];
    endfunction

    function automatic logic [5:0] f_sat_add6(input logic [5:0] a, input logic [5:0] b);
        logic [6:0] s;
        s = 7'(a) + 7'(b);
        return s[6] ? 6'h3F : s[5:0];
    endfunction

    // The quotient is the number of constant thresholds met, which tops out at 15.
    function automatic logic [3:0] f_fade_chan(input logic [3:0] c, input logic [7:0] pct);
        logic [11:0] prod;
        logic [3:0]  q;
        prod = 12'(c) * 12'(pct);
        q = '0;
        for (int k = 1; k < 16; k++) begin
            if (prod >= 12'(k * FadeDiv)) begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    function automatic logic [3:0] f_gray(input logic [15:0] p);
        logic [5:0] sum;
        logic [3:0] q;
        sum = 6'(p[11:8]) + 6'(p[7:4]) + 6'(p[3:0]);
        q = '0;
        for (int k = 1; k < 16; k++) begin
            if (sum >= 6'(k * GrayDiv)) begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

    logic [15:0] s;
    logic [15:0] d;
    logic [15:0] add_pix;
    logic [15:0] halve_pix;
    logic [15:0] fade_pix;
    logic [15:0] gray_pix;
    logic [3:0]  gray_c;
    logic        src_nz;
    logic        dest_key;

    assign s = i_req.src_pixel;
    assign d = i_req.dest_pixel;
    assign src_nz = (s != '0);
    assign dest_key = (d == KeyColor);

    always_comb begin
        if (i_cfg.pixel_format) begin
            add_pix = {f_sat_add5(s[15:11], d[15:11]), f_sat_add6(s[10:5], d[10:5]),
                       f_sat_add5(s[4:0], d[4:0])};
            halve_pix = {1'b0, s[15:12], 1'b0, s[10:6], 1'b0, s[4:1]};
        end else begin
            add_pix = {4'h0, f_sat_add4(s[11:8], d[11:8]), f_sat_add4(s[7:4], d[7:4]),
                       f_sat_add4(s[3:0], d[3:0])};
            halve_pix = {4'h0, 1'b0, s[11:9], 1'b0, s[7:5], 1'b0, s[3:1]};
        end
    end

    assign fade_pix = {4'h0, f_fade_chan(d[11:8], i_cfg.fade_percent),
                       f_fade_chan(d[7:4], i_cfg.fade_percent),
                       f_fade_chan(d[3:0], i_cfg.fade_percent)};
    assign gray_c = f_gray(d);
    assign gray_pix = {4'h0, gray_c, gray_c, gray_c};

    always_comb begin
        o_rsp.result_pixel = d;
        o_rsp.write_enable = 1'b0;
        o_rsp.last_out = i_req.last_in;
        unique case (t_kind'(i_req.kind))
            KIND_KEY_COPY: begin
                if (src_nz) begin
                    o_rsp.result_pixel = s;
                    o_rsp.write_enable = 1'b1;
                end
            end
            KIND_ADD: begin
                o_rsp.result_pixel = add_pix;
                o_rsp.write_enable = 1'b1;
            end
            KIND_HALVE: begin
                if (src_nz) begin
                    o_rsp.result_pixel = halve_pix;
                    o_rsp.write_enable = 1'b1;
                end
            end
            KIND_FADE: begin
                o_rsp.result_pixel = fade_pix;
                o_rsp.write_enable = 1'b1;
            end
            KIND_FADE_KEY: begin
                if (!dest_key) begin
                    o_rsp.result_pixel = fade_pix;
                    o_rsp.write_enable = 1'b1;
                end
            end
            KIND_GRAY: begin
                if (!dest_key) begin
                    o_rsp.result_pixel = gray_pix;
                    o_rsp.write_enable = 1'b1;
                end
            end
            default: begin
                o_rsp.write_enable = 1'b0;
            end
        endcase
    end

endmodule
